// ===== hdl/bqf_pkg.sv =====
// Biquad filter package: fixed-point widths, register indexes, step program.
// Self-contained; used by biquad_iir_filter.

package bqf_pkg;

  localparam int STATE_W    = 40;
  localparam int ACC_W      = STATE_W + 2;
  localparam int COEF_FRAC  = 14;
  localparam int ROUND_HALF = 1 << (COEF_FRAC - 1);
  localparam int CFG_IDX_W  = 3;
  localparam int STEP_W     = 4;

  // configuration register indexes, also used as coefficient selects
  localparam logic [CFG_IDX_W-1:0] REG_B0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_A2 = 3'd4;

  // accumulator operations
  localparam logic [2:0] ACC_HOLD   = 3'd0;
  localparam logic [2:0] ACC_ADD_D1 = 3'd1; // acc = sat(prod + delay_one)
  localparam logic [2:0] ACC_ADD_D2 = 3'd2; // acc = prod + delay_two
  localparam logic [2:0] ACC_SUB    = 3'd3; // acc = acc - prod
  localparam logic [2:0] ACC_LOAD   = 3'd4; // acc = prod

  localparam logic [STEP_W-1:0] STEP_FIRST = 4'd0;
  localparam logic [STEP_W-1:0] STEP_CLR   = 4'd8;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] coef_sel;  // multiplier coefficient
    logic                 use_y;     // multiplier operand: y instead of x
    logic [2:0]           acc_op;
    logic                 round_y;   // round and clamp acc into y
    logic                 wr_d1;
    logic                 wr_d2;
    logic                 clr_state;
    logic                 jmp_clr;   // jump to the clear step on a clear request
    logic                 last;
  } ctrl_word_t;

  function automatic ctrl_word_t ctrl_rom(input logic [STEP_W-1:0] step);
    ctrl_word_t w;
    w = '0;
    case (step)
      4'd0: begin w.coef_sel = REG_B0; w.jmp_clr = 1'b1; end
      4'd1: begin w.coef_sel = REG_B1; w.acc_op = ACC_ADD_D1; end
      4'd2: begin w.round_y = 1'b1; w.acc_op = ACC_ADD_D2; end
      4'd3: begin w.coef_sel = REG_A1; w.use_y = 1'b1; end
      4'd4: begin w.coef_sel = REG_B2; w.acc_op = ACC_SUB; end
      4'd5: begin
        w.coef_sel = REG_A2; w.use_y = 1'b1; w.wr_d1 = 1'b1; w.acc_op = ACC_LOAD;
      end
      4'd6: begin w.acc_op = ACC_SUB; end
      4'd7: begin w.wr_d2 = 1'b1; w.last = 1'b1; end
      STEP_CLR: begin w.clr_state = 1'b1; w.last = 1'b1; end
      default: begin w.last = 1'b1; end
    endcase
    return w;
  endfunction

  // saturate an accumulator value to the state range
  function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-STATE_W:0] top;
    top = v[ACC_W-1:STATE_W-1];
    if (top == '0 || top == '1) return v[STATE_W-1:0];
    else if (v[ACC_W-1]) return {1'b1, {(STATE_W-1){1'b0}}};
    else return {1'b0, {(STATE_W-1){1'b1}}};
  endfunction

endpackage

// ===== hdl/biquad_iir_filter.sv =====
// Biquad IIR filter, transposed direct form II, driven by a small step program.
// Depends on bqf_pkg (widths, register indexes, control ROM).
//
//   channel  | direction | contents
//   s_*      | in        | tdata: sample_in; tuser: op (1 = clear state)
//   m_*      | out       | tdata: sample_out; tuser: clipped
//   cfg_*    | in        | coefficient writes b0, b1, b2, a1, a2 at index 0..4
//
// A filter request runs 8 steps of one shared multiplier and accumulator; a clear
// request takes 2 steps. The next request is taken in the last step unless a stall
// holds that step. Reset (rst, synchronous) clears control and the two delay terms.
// A stalled result holds the last step until the output register frees.

module biquad_iir_filter
  import bqf_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16,
  parameter int COEF_WIDTH   = 18,
  localparam int DATA_W      = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [DATA_W-1:0]     s_tdata,   // sample_in
  input  logic                  s_tuser,   // op
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [DATA_W-1:0]     m_tdata,   // sample_out
  output logic                  m_tuser,   // clipped
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [COEF_WIDTH-1:0] cfg_data
);

  localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int WIDE_W = (PROD_W > ACC_W) ? PROD_W : ACC_W;
  localparam logic signed [WIDE_W-1:0] ST_MAX =
    {{(WIDE_W-STATE_W+1){1'b0}}, {(STATE_W-1){1'b1}}};
  localparam logic signed [WIDE_W-1:0] ST_MIN = ~ST_MAX;
  localparam logic signed [ACC_W-1:0] Y_MAX =
    {{(ACC_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] Y_MIN = ~Y_MAX;

  logic signed [COEF_WIDTH-1:0]   coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
  logic signed [STATE_W-1:0]      delay_one, delay_two;
  logic signed [SAMPLE_WIDTH-1:0] x, y;
  logic                           clip;
  logic                           clr_req;
  logic                           busy;
  logic [STEP_W-1:0]              step;
  logic signed [STATE_W-1:0]      prod;
  logic signed [ACC_W-1:0]        acc;

  ctrl_word_t                     cw;
  logic                           adv;
  logic                           s_accept;
  logic signed [SAMPLE_WIDTH-1:0] mul_a;
  logic signed [COEF_WIDTH-1:0]   mul_b;
  logic signed [PROD_W-1:0]       prod_full;
  logic signed [WIDE_W-1:0]       prod_wide;
  logic signed [STATE_W-1:0]      prod_next;
  logic signed [ACC_W-1:0]        prod_ext;
  logic signed [ACC_W-1:0]        rnd_sum, yr;
  logic                           clip_next;
  logic signed [SAMPLE_WIDTH-1:0] y_next;
  logic [SAMPLE_WIDTH-1:0]        out_sample;

  assign cw       = ctrl_rom(step);
  // hold the last step while the previous result is still waiting
  assign adv      = busy && !(cw.last && m_tvalid && !m_tready);
  assign s_tready = !rst && (!busy || (cw.last && adv));
  assign s_accept = s_tvalid && s_tready;

  // shared multiplier, product saturated to the state range
  always_comb begin
    mul_a = cw.use_y ? y : x;
    case (cw.coef_sel)
      REG_B0:  mul_b = coef_b0;
      REG_B1:  mul_b = coef_b1;
      REG_B2:  mul_b = coef_b2;
      REG_A1:  mul_b = coef_a1;
      REG_A2:  mul_b = coef_a2;
      default: mul_b = '0;
    endcase
    prod_full = mul_a * mul_b;
    prod_wide = WIDE_W'(prod_full);
    if (prod_wide > ST_MAX)      prod_next = ST_MAX[STATE_W-1:0];
    else if (prod_wide < ST_MIN) prod_next = ST_MIN[STATE_W-1:0];
    else                         prod_next = prod_wide[STATE_W-1:0];
  end

  assign prod_ext = ACC_W'(prod);

  // round half up, then clamp to the sample range
  always_comb begin
    rnd_sum   = acc + $signed(ACC_W'(ROUND_HALF));
    yr        = rnd_sum >>> COEF_FRAC;
    clip_next = (yr > Y_MAX) || (yr < Y_MIN);
    if (yr > Y_MAX)      y_next = Y_MAX[SAMPLE_WIDTH-1:0];
    else if (yr < Y_MIN) y_next = Y_MIN[SAMPLE_WIDTH-1:0];
    else                 y_next = yr[SAMPLE_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b0 <= COEF_WIDTH'(16'sd16384);
      coef_b1 <= '0;
      coef_b2 <= '0;
      coef_a1 <= '0;
      coef_a2 <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_B0:  coef_b0 <= cfg_data;
        REG_B1:  coef_b1 <= cfg_data;
        REG_B2:  coef_b2 <= cfg_data;
        REG_A1:  coef_a1 <= cfg_data;
        REG_A2:  coef_a2 <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= STEP_FIRST;
    end else if (s_accept) begin
      busy <= 1'b1;
      step <= STEP_FIRST;
    end else if (adv) begin
      if (cw.last)                    busy <= 1'b0;
      else if (cw.jmp_clr && clr_req) step <= STEP_CLR;
      else                            step <= step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      x       <= $signed(s_tdata[SAMPLE_WIDTH-1:0]);
      clr_req <= s_tuser;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_one <= '0;
      delay_two <= '0;
    end else if (adv) begin
      if (cw.clr_state) begin
        delay_one <= '0;
        delay_two <= '0;
      end else begin
        if (cw.wr_d1) delay_one <= sat_state(acc);
        if (cw.wr_d2) delay_two <= sat_state(acc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod <= prod_next;
      if (cw.round_y) begin
        y    <= y_next;
        clip <= clip_next;
      end
      case (cw.acc_op)
        ACC_ADD_D1: acc <= ACC_W'(sat_state(prod_ext + ACC_W'(delay_one)));
        ACC_ADD_D2: acc <= prod_ext + ACC_W'(delay_two);
        ACC_SUB:    acc <= acc - prod_ext;
        ACC_LOAD:   acc <= prod_ext;
        default:    ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv && cw.last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && cw.last) begin
      out_sample <= cw.clr_state ? '0 : y;
      m_tuser    <= cw.clr_state ? 1'b0 : clip;
    end
  end

  assign m_tdata = DATA_W'(out_sample);

endmodule

// ===== hdl/bqf_check.sv =====
// Port-level checks for biquad_iir_filter, bound to the top level.
// Depends on bqf_pkg for the configuration index width.

module bqf_check
  import bqf_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16,
  parameter int COEF_WIDTH   = 18,
  localparam int DATA_W      = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic [DATA_W-1:0]     s_tdata,   // sample_in
  input logic                  s_tuser,   // op
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [DATA_W-1:0]     m_tdata,   // sample_out
  input logic                  m_tuser,   // clipped
  input logic                  cfg_we,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [COEF_WIDTH-1:0] cfg_data
);

  localparam logic [SAMPLE_WIDTH-1:0] S_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic [SAMPLE_WIDTH-1:0] S_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // an accepted request closes the input for its first step
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while previous one in progress");

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // a clipped result sits at a range limit
  a_clip_limit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |->
      m_tdata[SAMPLE_WIDTH-1:0] == S_MAX || m_tdata[SAMPLE_WIDTH-1:0] == S_MIN)
    else $error("clipped flag on unsaturated sample");

endmodule

bind biquad_iir_filter bqf_check #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH),
  .COEF_WIDTH  (COEF_WIDTH)
) u_bqf_check (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .cfg_we   (cfg_we),
  .cfg_index(cfg_index),
  .cfg_data (cfg_data)
);
